### hdl/bnfa_pkg.sv
// Shared constants, codes and bit-vector helpers for the next-fit block allocator.
package bnfa_pkg;

    localparam int BNFA_POOL_BLOCKS = 4096;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_NO_SPACE    = 3'd1;
    localparam logic [2:0] STAT_INVALID     = 3'd2;
    localparam logic [2:0] STAT_START_RANGE = 3'd3;
    localparam logic [2:0] STAT_OVERRUN     = 3'd4;

    function automatic logic [31:0] bnfa_lowmask(input logic [5:0] n);
        logic [31:0] m;
        for (int i = 0; i < 32; i++) begin
            m[i] = (6'(i) < n);
        end
        return m;
    endfunction

    function automatic logic [4:0] bnfa_lowest_one(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [4:0] bnfa_highest_one(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

### hdl/bnfa_map_ram.sv
// Used-bit map storage: one write port and one read port with registered read data.
module bnfa_map_ram
    import bnfa_pkg::*;
#(
    parameter int DEPTH = (BNFA_POOL_BLOCKS + 31) / 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data
);

    logic [31:0] map_mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/bnfa_word_eval.sv
// Evaluates one 32-bit word of free bits against the free run carried in from earlier words.
module bnfa_word_eval
    import bnfa_pkg::*;
#(
    parameter int IW = 13
) (
    input  logic [31:0]   free_vec,
    input  logic [IW-1:0] need,
    input  logic [IW-1:0] run_in,
    input  logic [IW-1:0] run_start_in,
    input  logic [IW-1:0] base,
    output logic          hit,
    output logic [IW-1:0] hit_first,
    output logic [IW-1:0] run_out,
    output logic [IW-1:0] run_start_out
);

    logic [IW-1:0] k_left;
    logic          a_hit;
    logic [31:0]   a_mask;
    logic [IW-1:0] a_first;
    logic          need_small;
    logic [5:0]    need6;
    logic [31:0]   b_mask;
    logic [31:0]   b_vec;
    logic          b_hit;
    logic [4:0]    b_pos;
    logic [4:0]    top_used;
    logic [5:0]    top_free;

    assign k_left  = need - run_in;
    assign a_mask  = bnfa_lowmask(k_left[5:0]);
    assign a_hit   = (k_left <= IW'(32)) && ((free_vec & a_mask) == a_mask);
    assign a_first = (run_in == '0) ? base : run_start_in;

    assign need_small = (need <= IW'(32));
    assign need6      = need[5:0];
    assign b_mask     = bnfa_lowmask(need6);

    always_comb begin
        for (int j = 0; j < 32; j++) begin
            b_vec[j] = need_small && ((7'(j) + {1'b0, need6}) <= 7'd32)
                       && ((free_vec & (b_mask << j)) == (b_mask << j));
        end
    end

    assign b_hit    = |b_vec;
    assign b_pos    = bnfa_lowest_one(b_vec);
    assign top_used = bnfa_highest_one(~free_vec);
    assign top_free = 6'd31 - {1'b0, top_used};

    assign hit       = a_hit || b_hit;
    assign hit_first = a_hit ? a_first : (base + IW'(b_pos));

    always_comb begin
        if (&free_vec) begin
            run_out       = run_in + IW'(32);
            run_start_out = a_first;
        end else begin
            run_out       = IW'(top_free);
            run_start_out = base + IW'(6'd32 - top_free);
        end
    end

endmodule

### hdl/bitmap_next_fit_block_allocator_core.sv
// Next-fit block allocator: used-bit map in a word memory, command sequencer and result register.
//
// Input beats (s_valid/s_ready) carry a command: allocate a run of blocks, free a region, or
// clear the map. Each command gives exactly one result beat (m_valid/m_ready) with a status and,
// for a successful allocate, the first block of the granted run.
// One command is worked on at a time. The map memory is read one 32-bit word per cycle, so the
// cost is set by the words that each phase sweeps (W = ceil(POOL_BLOCKS / 32), 128 by default):
//   allocate: scanned words, then the words marked, then the words searched for the new hint;
//   free:     the words spanned by the region; argument errors read no map words;
//   clear:    all W words.
// After reset the block clears the map, one word per cycle, before s_ready rises.
// A finished result is held in the output register while m_ready is low; the next command is
// accepted meanwhile, and its own result waits until the register has been emptied.
module bitmap_next_fit_block_allocator_core
    import bnfa_pkg::*;
#(
    parameter int POOL_BLOCKS = BNFA_POOL_BLOCKS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_request_size,
    input  logic [15:0] s_region_start,
    input  logic        s_region_absent,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [11:0] m_granted_block
);

    localparam int BW        = $clog2(POOL_BLOCKS);
    localparam int IW        = (BW + 1 > 6) ? BW + 1 : 6;
    localparam int WN        = IW - 5;
    localparam int MAP_WORDS = (POOL_BLOCKS + 31) / 32;
    localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [IW-1:0] POOL_IW = IW'(POOL_BLOCKS);
    localparam logic [WN-1:0] LAST_W  = WN'(MAP_WORDS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_HINT  = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [WN-1:0] ptr_reg, ptr_next;
    logic [WN-1:0] end_reg, end_next;
    logic          issuing_reg, issuing_next;
    logic [WN-1:0] dptr_reg, dptr_next;
    logic          dvld_reg, dvld_next;
    logic          pass_reg, pass_next;
    logic [IW-1:0] need_reg, need_next;
    logic          zero_reg, zero_next;
    logic [IW-1:0] lo_reg, lo_next;
    logic [IW-1:0] hi_reg, hi_next;
    logic [IW-1:0] run_reg, run_next;
    logic [IW-1:0] rstart_reg, rstart_next;
    logic [IW-1:0] first_reg, first_next;
    logic [IW-1:0] last_reg, last_next;
    logic          set_reg, set_next;
    logic          sweep_cmd_reg, sweep_cmd_next;
    logic [IW-1:0] hint_reg, hint_next;
    logic [2:0]    pend_status_reg, pend_status_next;
    logic [11:0]   pend_granted_reg, pend_granted_next;
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [11:0]   m_granted_reg, m_granted_next;

    logic          rd_en;
    logic [31:0]   rd_data;
    logic          wr_en;
    logic [WA-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [IW-1:0] base;
    logic [WN-1:0] lo_w, hi_w, first_w, last_w;
    logic [31:0]   m_lo, m_hi, m_first, m_last, range_mask, mod_mask, free_vec;
    logic          ev_hit;
    logic [IW-1:0] ev_first, ev_run, ev_rstart;
    logic [31:0]   size_ext, start_ext, end_ext;
    logic [IW-1:0] hint_m1, hit_last, after_run;

    bnfa_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WA)
    ) u_map (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (WA'(ptr_reg)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign base    = {dptr_reg, 5'b0};
    assign lo_w    = lo_reg[IW-1:5];
    assign hi_w    = hi_reg[IW-1:5];
    assign first_w = first_reg[IW-1:5];
    assign last_w  = last_reg[IW-1:5];

    assign m_lo = (dptr_reg == lo_w) ? (32'hFFFF_FFFF << lo_reg[4:0])
                                     : ((dptr_reg > lo_w) ? 32'hFFFF_FFFF : 32'h0);
    assign m_hi = (dptr_reg == hi_w) ? bnfa_lowmask({1'b0, hi_reg[4:0]})
                                     : ((dptr_reg < hi_w) ? 32'hFFFF_FFFF : 32'h0);
    assign range_mask = m_lo & m_hi;
    assign free_vec   = ~rd_data & range_mask;

    assign m_first  = (dptr_reg == first_w) ? (32'hFFFF_FFFF << first_reg[4:0]) : 32'hFFFF_FFFF;
    assign m_last   = (dptr_reg == last_w) ? bnfa_lowmask({1'b0, last_reg[4:0]} + 6'd1)
                                           : 32'hFFFF_FFFF;
    assign mod_mask = m_first & m_last;

    bnfa_word_eval #(
        .IW (IW)
    ) u_eval (
        .free_vec      (free_vec),
        .need          (need_reg),
        .run_in        (run_reg),
        .run_start_in  (rstart_reg),
        .base          (base),
        .hit           (ev_hit),
        .hit_first     (ev_first),
        .run_out       (ev_run),
        .run_start_out (ev_rstart)
    );

    assign size_ext  = 32'(s_request_size);
    assign start_ext = 32'(s_region_start);
    assign end_ext   = start_ext + size_ext - 32'd1;
    assign hint_m1   = hint_reg - IW'(1);
    assign hit_last  = ev_first + need_reg - IW'(1);
    assign after_run = last_reg + IW'(1);

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        end_next          = end_reg;
        issuing_next      = issuing_reg;
        pass_next         = pass_reg;
        need_next         = need_reg;
        zero_next         = zero_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        run_next          = run_reg;
        rstart_next       = rstart_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        set_next          = set_reg;
        sweep_cmd_next    = sweep_cmd_reg;
        hint_next         = hint_reg;
        pend_status_next  = pend_status_reg;
        pend_granted_next = pend_granted_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_granted_next    = m_granted_reg;
        wr_en             = 1'b0;
        wr_addr           = WA'(dptr_reg);
        wr_data           = 32'h0;

        rd_en     = issuing_reg;
        dvld_next = issuing_reg;
        dptr_next = ptr_reg;
        if (issuing_reg) begin
            if (ptr_reg == end_reg) begin
                issuing_next = 1'b0;
            end else begin
                ptr_next = ptr_reg + WN'(1);
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        CMD_ALLOC: begin
                            if (size_ext > 32'(POOL_BLOCKS)) begin
                                pend_status_next  = STAT_NO_SPACE;
                                pend_granted_next = 12'd0;
                                state_next        = S_RESP;
                            end else begin
                                need_next    = (s_request_size == 16'd0) ? IW'(1)
                                                                         : IW'(s_request_size);
                                zero_next    = (s_request_size == 16'd0);
                                pass_next    = 1'b0;
                                lo_next      = hint_reg;
                                hi_next      = POOL_IW;
                                run_next     = '0;
                                rstart_next  = '0;
                                ptr_next     = hint_reg[IW-1:5];
                                end_next     = LAST_W;
                                issuing_next = 1'b1;
                                state_next   = S_SCAN;
                            end
                        end
                        CMD_FREE: begin
                            pend_granted_next = 12'd0;
                            if (s_region_absent || (s_request_size == 16'd0)) begin
                                pend_status_next = STAT_INVALID;
                                state_next       = S_RESP;
                            end else if (start_ext >= 32'(POOL_BLOCKS)) begin
                                pend_status_next = STAT_START_RANGE;
                                state_next       = S_RESP;
                            end else if (end_ext >= 32'(POOL_BLOCKS)) begin
                                pend_status_next = STAT_OVERRUN;
                                state_next       = S_RESP;
                            end else begin
                                first_next   = IW'(start_ext);
                                last_next    = IW'(end_ext);
                                set_next     = 1'b0;
                                ptr_next     = start_ext[IW-1:5];
                                end_next     = end_ext[IW-1:5];
                                issuing_next = 1'b1;
                                state_next   = S_MOD;
                            end
                        end
                        CMD_CLEAR: begin
                            ptr_next       = '0;
                            sweep_cmd_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        default: begin
                            pend_status_next  = STAT_INVALID;
                            pend_granted_next = 12'd0;
                            state_next        = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (dvld_reg) begin
                    run_next    = ev_run;
                    rstart_next = ev_rstart;
                    if (ev_hit) begin
                        dvld_next = 1'b0;
                        if (zero_reg) begin
                            hint_next         = ev_first;
                            pend_status_next  = STAT_OK;
                            pend_granted_next = 12'(ev_first);
                            issuing_next      = 1'b0;
                            state_next        = S_RESP;
                        end else begin
                            first_next   = ev_first;
                            last_next    = hit_last;
                            set_next     = 1'b1;
                            ptr_next     = ev_first[IW-1:5];
                            end_next     = hit_last[IW-1:5];
                            issuing_next = 1'b1;
                            state_next   = S_MOD;
                        end
                    end else if (dptr_reg == end_reg) begin
                        dvld_next = 1'b0;
                        if (!pass_reg && (hint_reg != '0)) begin
                            pass_next    = 1'b1;
                            lo_next      = '0;
                            hi_next      = hint_reg;
                            run_next     = '0;
                            rstart_next  = '0;
                            ptr_next     = '0;
                            end_next     = hint_m1[IW-1:5];
                            issuing_next = 1'b1;
                        end else begin
                            pend_status_next  = STAT_NO_SPACE;
                            pend_granted_next = 12'd0;
                            issuing_next      = 1'b0;
                            state_next        = S_RESP;
                        end
                    end
                end
            end
            S_MOD: begin
                if (dvld_reg) begin
                    wr_en   = 1'b1;
                    wr_data = set_reg ? (rd_data | mod_mask) : (rd_data & ~mod_mask);
                    if (dptr_reg == end_reg) begin
                        dvld_next = 1'b0;
                        if (set_reg) begin
                            pend_granted_next = 12'(first_reg);
                            if (after_run >= POOL_IW) begin
                                hint_next        = '0;
                                pend_status_next = STAT_OK;
                                state_next       = S_RESP;
                            end else begin
                                lo_next      = after_run;
                                hi_next      = POOL_IW;
                                ptr_next     = after_run[IW-1:5];
                                end_next     = LAST_W;
                                issuing_next = 1'b1;
                                state_next   = S_HINT;
                            end
                        end else begin
                            if (first_reg < hint_reg) begin
                                hint_next = first_reg;
                            end
                            pend_status_next  = STAT_OK;
                            pend_granted_next = 12'd0;
                            state_next        = S_RESP;
                        end
                    end
                end
            end
            S_HINT: begin
                if (dvld_reg) begin
                    if (|free_vec) begin
                        hint_next        = base + IW'(bnfa_lowest_one(free_vec));
                        pend_status_next = STAT_OK;
                        dvld_next        = 1'b0;
                        issuing_next     = 1'b0;
                        state_next       = S_RESP;
                    end else if (dptr_reg == end_reg) begin
                        hint_next        = '0;
                        pend_status_next = STAT_OK;
                        dvld_next        = 1'b0;
                        state_next       = S_RESP;
                    end
                end
            end
            S_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = WA'(ptr_reg);
                wr_data = 32'h0;
                if (ptr_reg == LAST_W) begin
                    hint_next = '0;
                    if (sweep_cmd_reg) begin
                        pend_status_next  = STAT_OK;
                        pend_granted_next = 12'd0;
                        state_next        = S_RESP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    ptr_next = ptr_reg + WN'(1);
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = pend_status_reg;
                    m_granted_next = pend_granted_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            ptr_reg       <= '0;
            issuing_reg   <= 1'b0;
            dvld_reg      <= 1'b0;
            sweep_cmd_reg <= 1'b0;
            hint_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            issuing_reg   <= issuing_next;
            dvld_reg      <= dvld_next;
            sweep_cmd_reg <= sweep_cmd_next;
            hint_reg      <= hint_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_reg          <= end_next;
        dptr_reg         <= dptr_next;
        pass_reg         <= pass_next;
        need_reg         <= need_next;
        zero_reg         <= zero_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        run_reg          <= run_next;
        rstart_reg       <= rstart_next;
        first_reg        <= first_next;
        last_reg         <= last_next;
        set_reg          <= set_next;
        pend_status_reg  <= pend_status_next;
        pend_granted_reg <= pend_granted_next;
        m_status_reg     <= m_status_next;
        m_granted_reg    <= m_granted_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_block = m_granted_reg;

`ifndef SYNTH
    a_hint_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg < POOL_IW)
        else $error("Search hint left the pool.");

    a_data_in_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        dvld_reg |-> (state_reg == S_SCAN || state_reg == S_MOD || state_reg == S_HINT))
        else $error("Map read data arrived outside a scanning phase.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("A second command beat was taken while one is in progress.");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid && !m_ready)) |-> $past(state_reg == S_RESP))
        else $error("A result beat appeared without a finished command.");
`endif

endmodule
